FILE: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared action and status codes for the double-ended queue with search.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  // Action codes carried by an input word.
  typedef logic [2:0] action_t;
  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_PUSH_BACK  = 3'd1;
  localparam action_t ACT_POP_FRONT  = 3'd2;
  localparam action_t ACT_POP_BACK   = 3'd3;
  localparam action_t ACT_SEARCH     = 3'd4;
  localparam action_t ACT_STATUS     = 3'd5;

  // Status codes reported in every result word.
  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Ring storage for the queue: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic signed [31:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic signed [31:0]     rd_data
);

  logic signed [31:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue_with_search.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// Double-ended queue of signed 32-bit words in a ring memory, with a search
// that walks the stored entries from the front through one compare unit.
// ----------------------------------------------------------------------------
// An accepted word steps through S_RD_FRONT, S_RD_BACK (if still non-empty)
// and S_DONE, which waits for a free output register; a non-empty search first
// walks S_SEARCH to a hit or the end. Throughput: one word at a time; input
// ready rises with the result, and the single read port, which fetches front,
// back and each searched entry in turn, sets the pace.
// Reset (synchronous, active high) empties the queue; memory is not cleared.
`default_nettype none

module double_ended_queue_with_search
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         action,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic                    found,
  output logic [3:0]              position,
  output logic [4:0]              occupancy,
  output logic                    is_empty,
  output logic signed [31:0]      front_value,
  output logic signed [31:0]      back_value
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_RD_FRONT,
    S_RD_BACK,
    S_DONE
  } state_t;

  state_t             state;
  logic [AW-1:0]      front;
  logic [CW-1:0]      count;
  logic signed [31:0] value_r;
  logic [CW-1:0]      issue_idx;
  logic [AW-1:0]      cmp_idx;
  logic               cmp_valid;
  logic               found_r;
  logic [AW-1:0]      pos_r;
  status_t            status_r;
  logic signed [31:0] front_r;

  logic               accept;
  logic               is_push;
  logic               is_full;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_data;
  logic [AW-1:0]      front_dec;
  logic [AW-1:0]      front_inc;
  logic               match;
  logic               out_free;

  // Ring slot that lies a given offset behind the front entry.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW + 1)'(off);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign is_push   = (action == ACT_PUSH_FRONT) || (action == ACT_PUSH_BACK);
  assign is_full   = (count == CNT_FULL);
  assign front_dec = (front == '0) ? LAST_SLOT : front - 1'b1;
  assign front_inc = (front == LAST_SLOT) ? '0 : front + 1'b1;
  assign out_free  = !out_valid || out_ready;

  // A push writes its word at the edge where it is accepted.
  assign wr_en   = accept && is_push && !is_full;
  assign wr_addr = (action == ACT_PUSH_FRONT) ? front_dec : slot_of(front, count);

  // The one read port serves the search walk and the front and back fetch.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = front;
    case (state)
      S_SEARCH: begin
        rd_en   = (issue_idx != count);
        rd_addr = slot_of(front, issue_idx);
      end
      S_RD_FRONT: begin
        rd_en   = (count != '0);
        rd_addr = front;
      end
      S_RD_BACK: begin
        rd_en   = 1'b1;
        rd_addr = slot_of(front, count - 1'b1);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = front;
      end
    endcase
  end

  // Shared compare unit: the entry fetched last cycle against the key.
  assign match = cmp_valid && (rd_data == value_r);

  deq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer, queue pointers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            value_r   <= value;
            status_r  <= ST_OK;
            found_r   <= 1'b0;
            pos_r     <= '0;
            issue_idx <= '0;
            cmp_valid <= 1'b0;
            state     <= S_RD_FRONT;
            case (action)
              ACT_PUSH_FRONT: begin
                if (is_full) begin
                  status_r <= ST_FULL;
                end else begin
                  front <= front_dec;
                  count <= count + 1'b1;
                end
              end
              ACT_PUSH_BACK: begin
                if (is_full) begin
                  status_r <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              ACT_POP_FRONT: begin
                if (count == '0) begin
                  status_r <= ST_EMPTY;
                end else begin
                  front <= front_inc;
                  count <= count - 1'b1;
                end
              end
              ACT_POP_BACK: begin
                if (count == '0) begin
                  status_r <= ST_EMPTY;
                end else begin
                  count <= count - 1'b1;
                end
              end
              ACT_SEARCH: begin
                if (count != '0) begin
                  state <= S_SEARCH;
                end
              end
              default: begin
                // Status query and unused codes leave the queue alone.
              end
            endcase
          end
        end
        S_SEARCH: begin
          // Issue one read per cycle and compare the one fetched before.
          if (rd_en) begin
            issue_idx <= issue_idx + 1'b1;
            cmp_idx   <= issue_idx[AW-1:0];
          end
          cmp_valid <= rd_en;
          if (match) begin
            found_r   <= 1'b1;
            pos_r     <= cmp_idx;
            cmp_valid <= 1'b0;
            state     <= S_RD_FRONT;
          end else if (!cmp_valid && issue_idx == count) begin
            state <= S_RD_FRONT;
          end
        end
        S_RD_FRONT: begin
          state <= (count == '0) ? S_DONE : S_RD_BACK;
        end
        S_RD_BACK: begin
          front_r <= rd_data;
          state   <= S_DONE;
        end
        S_DONE: begin
          // Load the result once the output register is free.
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= status_r;
            found     <= found_r;
            position  <= 4'(pos_r);
            occupancy <= 5'(count);
            is_empty  <= (count == '0);
            if (count == '0) begin
              front_value <= '0;
              back_value  <= -32'sd1;
            end else begin
              front_value <= front_r;
              back_value  <= rd_data;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The count never passes the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("entry count exceeds depth");

  // A search walk only runs on a non-empty queue.
  a_search_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (count != '0))
    else $error("search walk on empty queue");

  // An accepted push into a queue with room grows it by one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && is_push && !is_full) |=> (count == $past(count) + 1'b1))
    else $error("push did not grow the queue");

  // An empty result carries the fixed front and back values.
  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> (front_value == '0 && back_value == -32'sd1
                                 && occupancy == '0))
    else $error("empty result with wrong values");

  // A rejected push reports a full queue.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (occupancy == 5'(DEPTH)))
    else $error("full status without full queue");

endmodule

`default_nettype wire
